// ===== hdl/assert_macros.svh =====
// Assertion macros for the anchor pose transform RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ARPT_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("arpt assertion failed");

// Next-cycle implication, checked out of reset.
`define ARPT_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("arpt assertion failed");

`endif

// ===== hdl/arpt_pkg.sv =====
// Package for the anchor relative pose transform: types, codes, stage
// numbering and the shared fixed-point rounding and clamping functions.
package arpt_pkg;

  localparam int QF = 14;
  localparam int NORM_LAT = 53;
  localparam int Q2M_LAT = 2;

  localparam int L_IN  = 1;
  localparam int L_A   = L_IN + NORM_LAT;
  localparam int L_PP  = L_A + 3;
  localparam int L_POS = L_A + 4;
  localparam int L_B   = L_A + 2 + NORM_LAT;
  localparam int L_C   = L_B + Q2M_LAT;
  localparam int L_TOT = L_C + 1;

  typedef logic signed [15:0] q_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_ANCHOR_ZERO = 2'd1,
    ST_FRAME_ZERO  = 2'd2
  } status_e;

  localparam logic [2:0] CFG_ANCHOR_X  = 3'd0;
  localparam logic [2:0] CFG_ANCHOR_Y  = 3'd1;
  localparam logic [2:0] CFG_ANCHOR_Z  = 3'd2;
  localparam logic [2:0] CFG_ANCHOR_QX = 3'd3;
  localparam logic [2:0] CFG_ANCHOR_QY = 3'd4;
  localparam logic [2:0] CFG_ANCHOR_QZ = 3'd5;
  localparam logic [2:0] CFG_ANCHOR_QW = 3'd6;

  localparam q_t ONE = q_t'(1 << QF);
  localparam logic signed [63:0] ONE2 = 64'sd1 <<< (2 * QF);

  // Drops QF fraction bits, rounding halves away from zero.
  function automatic logic signed [63:0] rnd_q(input logic signed [63:0] v);
    logic [63:0] m;
    m = v[63] ? (~v + 64'd1) : v;
    m = (m + (64'd1 << (QF - 1))) >> QF;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic q_t clamp_one(input logic signed [63:0] v);
    if (v > 64'(ONE)) begin
      return ONE;
    end else if (v < -64'(ONE)) begin
      return -ONE;
    end
    return v[15:0];
  endfunction

endpackage

// ===== hdl/anchor_relative_pose_transform_core.sv =====
// Top level of the anchor relative pose transform pipeline.
// Uses arpt_pkg, arpt_norm, arpt_q2m and assert_macros.svh.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i/in_ready_o   ref_pos_*_i, ref_q*_i, last_in_i
//   out      output     out_valid_o/out_ready_i rel_pos_*_o, rot_*_o, status_o, last_out_o
//   cfg      input      cfg_we_i                cfg_idx_i, cfg_data_i
//
// One item enters per cycle while the output does not stall; the pipeline depth is
// dominated by two chained normalizers whose square root and divider retire one bit per stage.
// Reset clears the valid bits and the anchor to the identity pose.
// A stall freezes the whole pipeline; a one-item skid register takes the item offered
// during a stall, and in_ready_o stays low while that register is full.
`include "assert_macros.svh"

module anchor_relative_pose_transform_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [31:0]  ref_pos_x_i,
  input  logic signed [31:0]  ref_pos_y_i,
  input  logic signed [31:0]  ref_pos_z_i,
  input  logic signed [15:0]  ref_qx_i,
  input  logic signed [15:0]  ref_qy_i,
  input  logic signed [15:0]  ref_qz_i,
  input  logic signed [15:0]  ref_qw_i,
  input  logic                last_in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  rel_pos_x_o,
  output logic signed [31:0]  rel_pos_y_o,
  output logic signed [31:0]  rel_pos_z_o,
  output logic signed [15:0]  rot_r0c0_o,
  output logic signed [15:0]  rot_r0c1_o,
  output logic signed [15:0]  rot_r1c0_o,
  output logic signed [15:0]  rot_r1c1_o,
  output logic signed [15:0]  rot_r2c0_o,
  output logic signed [15:0]  rot_r2c1_o,
  output logic [1:0]          status_o,
  output logic                last_out_o
);
  import arpt_pkg::*;

  logic signed [31:0] anc_pos_q [3];
  q_t                 anc_q_q [4];

  logic               en;
  logic               skid_v_q;
  logic signed [31:0] skid_pos_q [3];
  q_t                 skid_q_q [4];
  logic               skid_last_q;
  logic signed [31:0] src_pos [3];
  q_t                 src_q [4];
  logic               src_last;

  logic               valid_q [L_IN:L_TOT];
  logic               last_q [L_IN:L_TOT];
  logic signed [32:0] d_q [L_IN:L_A+2][3];
  q_t                 rq_q [4];
  status_e            stat_q [L_A+1:L_TOT];
  logic signed [31:0] pr_q [4][4];
  q_t                 rel_q [4];
  logic signed [48:0] pp_q [3][3];
  logic signed [31:0] pos_q [L_POS:L_C][3];

  q_t                 au [4];
  q_t                 ru [4];
  q_t                 relu [4];
  q_t                 am [9];
  q_t                 rm [9];
  logic               anz, rnz, relnz;

  status_e            stat_a_d, stat_b_d;
  q_t                 rel_d [4];
  logic signed [31:0] pos_d [3];

  logic signed [31:0] o_pos_q [3];
  q_t                 o_rot_q [6];
  status_e            o_stat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anc_pos_q <= '{default: '0};
      anc_q_q <= '{16'sd0, 16'sd0, 16'sd0, ONE};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ANCHOR_X:  anc_pos_q[0] <= cfg_data_i;
        CFG_ANCHOR_Y:  anc_pos_q[1] <= cfg_data_i;
        CFG_ANCHOR_Z:  anc_pos_q[2] <= cfg_data_i;
        CFG_ANCHOR_QX: anc_q_q[0] <= cfg_data_i[15:0];
        CFG_ANCHOR_QY: anc_q_q[1] <= cfg_data_i[15:0];
        CFG_ANCHOR_QZ: anc_q_q[2] <= cfg_data_i[15:0];
        CFG_ANCHOR_QW: anc_q_q[3] <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign en = !valid_q[L_TOT] || out_ready_i;
  assign in_ready_o = !skid_v_q;

  always_comb begin
    if (skid_v_q) begin
      src_pos = skid_pos_q;
      src_q = skid_q_q;
      src_last = skid_last_q;
    end else begin
      src_pos = '{ref_pos_x_i, ref_pos_y_i, ref_pos_z_i};
      src_q = '{ref_qx_i, ref_qy_i, ref_qz_i, ref_qw_i};
      src_last = last_in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
      valid_q <= '{default: 1'b0};
    end else begin
      if (en) begin
        skid_v_q <= 1'b0;
        valid_q[L_IN] <= skid_v_q || in_valid_i;
        for (int s = L_IN + 1; s <= L_TOT; s++) begin
          valid_q[s] <= valid_q[s - 1];
        end
      end else if (in_valid_i && !skid_v_q) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!en && in_valid_i && !skid_v_q) begin
      skid_pos_q <= src_pos;
      skid_q_q <= src_q;
      skid_last_q <= src_last;
    end
  end

  arpt_norm u_norm_anchor (.clk_i, .en_i(en), .q_i(anc_q_q), .u_o(au), .nz_o(anz));
  arpt_norm u_norm_ref   (.clk_i, .en_i(en), .q_i(rq_q),    .u_o(ru), .nz_o(rnz));
  arpt_norm u_norm_rel   (.clk_i, .en_i(en), .q_i(rel_q),   .u_o(relu), .nz_o(relnz));
  arpt_q2m  u_q2m_anchor (.clk_i, .en_i(en), .q_i(au),   .m_o(am));
  arpt_q2m  u_q2m_rel    (.clk_i, .en_i(en), .q_i(relu), .m_o(rm));

  always_comb begin
    logic signed [63:0] acc;
    if (!anz) begin
      stat_a_d = ST_ANCHOR_ZERO;
    end else if (!rnz) begin
      stat_a_d = ST_FRAME_ZERO;
    end else begin
      stat_a_d = ST_OK;
    end
    stat_b_d = (stat_q[L_B] == ST_OK && !relnz) ? ST_FRAME_ZERO : stat_q[L_B];
    rel_d[0] = clamp_one(rnd_q(64'(pr_q[3][0]) - 64'(pr_q[0][3])
                               - 64'(pr_q[1][2]) + 64'(pr_q[2][1])));
    rel_d[1] = clamp_one(rnd_q(64'(pr_q[3][1]) + 64'(pr_q[0][2])
                               - 64'(pr_q[1][3]) - 64'(pr_q[2][0])));
    rel_d[2] = clamp_one(rnd_q(64'(pr_q[3][2]) - 64'(pr_q[0][1])
                               + 64'(pr_q[1][0]) - 64'(pr_q[2][3])));
    rel_d[3] = clamp_one(rnd_q(64'(pr_q[3][3]) + 64'(pr_q[0][0])
                               + 64'(pr_q[1][1]) + 64'(pr_q[2][2])));
    for (int k = 0; k < 3; k++) begin
      acc = rnd_q(64'(pp_q[0][k])) + rnd_q(64'(pp_q[1][k])) + rnd_q(64'(pp_q[2][k]));
      if (acc > 64'sd2147483647) begin
        pos_d[k] = 32'sh7FFFFFFF;
      end else if (acc < -64'sd2147483648) begin
        pos_d[k] = 32'sh80000000;
      end else begin
        pos_d[k] = acc[31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      last_q[L_IN] <= src_last;
      rq_q <= src_q;
      for (int i = 0; i < 3; i++) begin
        d_q[L_IN][i] <= 33'(src_pos[i]) - 33'(anc_pos_q[i]);
      end
      for (int s = L_IN + 1; s <= L_TOT; s++) begin
        last_q[s] <= last_q[s - 1];
      end
      for (int s = L_IN + 1; s <= L_A + 2; s++) begin
        d_q[s] <= d_q[s - 1];
      end
      stat_q[L_A + 1] <= stat_a_d;
      for (int s = L_A + 2; s <= L_TOT; s++) begin
        stat_q[s] <= (s == L_B + 1) ? stat_b_d : stat_q[s - 1];
      end
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          pr_q[i][j] <= au[i] * ru[j];
        end
      end
      rel_q <= rel_d;
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          pp_q[i][k] <= am[i * 3 + k] * d_q[L_A + 2][i];
        end
      end
      pos_q[L_POS] <= pos_d;
      for (int s = L_POS + 1; s <= L_C; s++) begin
        pos_q[s] <= pos_q[s - 1];
      end
      if (stat_q[L_C] == ST_OK) begin
        o_pos_q <= pos_q[L_C];
        o_rot_q <= '{rm[0], rm[1], rm[3], rm[4], rm[6], rm[7]};
      end else begin
        o_pos_q <= '{default: '0};
        o_rot_q <= '{default: '0};
      end
      o_stat_q <= stat_q[L_C];
    end
  end

  assign out_valid_o = valid_q[L_TOT];
  assign rel_pos_x_o = o_pos_q[0];
  assign rel_pos_y_o = o_pos_q[1];
  assign rel_pos_z_o = o_pos_q[2];
  assign rot_r0c0_o = o_rot_q[0];
  assign rot_r0c1_o = o_rot_q[1];
  assign rot_r1c0_o = o_rot_q[2];
  assign rot_r1c1_o = o_rot_q[3];
  assign rot_r2c0_o = o_rot_q[4];
  assign rot_r2c1_o = o_rot_q[5];
  assign status_o = o_stat_q;
  assign last_out_o = last_q[L_TOT];

  `ARPT_ASSERT_IMP(a_zero_on_error, out_valid_o && status_o != ST_OK,
    rel_pos_x_o == 32'sd0 && rot_r0c0_o == 16'sd0 && rot_r1c1_o == 16'sd0)
  `ARPT_ASSERT_NXT(a_skid_kept, skid_v_q && !en, skid_v_q)
  `ARPT_ASSERT_IMP(a_rot_range, out_valid_o && status_o == ST_OK,
    rot_r0c0_o <= 16'sd16384 && rot_r0c0_o >= -16'sd16384)

endmodule

// ===== hdl/arpt_norm.sv =====
// Pipelined quaternion normalizer: sum of squares, bit-serial square root
// and restoring division, one result bit per stage. Uses arpt_pkg.
module arpt_norm (
  input  logic          clk_i,
  input  logic          en_i,
  input  arpt_pkg::q_t  q_i [4],
  output arpt_pkg::q_t  u_o [4],
  output logic          nz_o
);
  import arpt_pkg::*;

  localparam int SQ0 = 3;
  localparam int SQN = 34;
  localparam int DV0 = 35;
  localparam int DVN = 51;
  localparam int LST = NORM_LAT - 1;

  typedef struct packed {
    logic [3:0][15:0] mag;
    logic [3:0]       neg;
    logic [5:0]       e;
    logic             nz;
  } nctl_t;

  nctl_t       c_q [0:LST];
  nctl_t       c0_d, c2_d;
  logic [30:0] sq_q [4];
  logic [30:0] sq_d [4];
  logic [32:0] sum_sq;
  logic [63:0] x_q, x_d;
  logic [63:0] rem_q [SQ0:SQN];
  logic [63:0] rem_d [SQ0:SQN];
  logic [31:0] res_q [SQ0:SQN];
  logic [31:0] res_d [SQ0:SQN];
  logic [47:0] dn_q [DV0:DVN][4];
  logic [47:0] dn_d [DV0:DVN][4];
  logic [15:0] qt_q [DV0:DVN][4];
  logic [15:0] qt_d [DV0:DVN][4];
  logic [31:0] root_q [DV0:DVN];
  logic [31:0] root_d [DV0:DVN];
  q_t          u_q [4];
  q_t          u_d [4];

  always_comb begin
    logic [6:0] bl;
    c0_d = '0;
    for (int i = 0; i < 4; i++) begin
      c0_d.neg[i] = q_i[i][15];
      c0_d.mag[i] = q_i[i][15] ? (~q_i[i] + 16'd1) : q_i[i];
      sq_d[i] = 31'(32'(c_q[0].mag[i]) * 32'(c_q[0].mag[i]));
    end
    sum_sq = 33'(sq_q[0]) + 33'(sq_q[1]) + 33'(sq_q[2]) + 33'(sq_q[3]);
    bl = '0;
    for (int i = 0; i < 33; i++) begin
      if (sum_sq[i]) begin
        bl = 7'(i + 1);
      end
    end
    c2_d = c_q[1];
    c2_d.e = 6'((7'd64 - bl) >> 1);
    c2_d.nz = (sum_sq != '0);
    x_d = 64'(sum_sq) << {c2_d.e, 1'b0};
  end

  always_comb begin
    logic [65:0] t, r;
    logic [31:0] rs;
    for (int i = 0; i < 32; i++) begin
      r = (i == 0) ? 66'(x_q) : 66'(rem_q[SQ0 + i - 1]);
      rs = (i == 0) ? '0 : res_q[SQ0 + i - 1];
      t = (66'(rs) << (32 - i)) | (66'd1 << (2 * (31 - i)));
      if (r >= t) begin
        rem_d[SQ0 + i] = 64'(r - t);
        res_d[SQ0 + i] = rs | (32'd1 << (31 - i));
      end else begin
        rem_d[SQ0 + i] = 64'(r);
        res_d[SQ0 + i] = rs;
      end
    end
  end

  always_comb begin
    logic [47:0] dv;
    root_d[DV0] = res_q[SQN];
    for (int j = 0; j < 4; j++) begin
      dn_d[DV0][j] = (48'(c_q[SQN].mag[j]) << (QF + int'(c_q[SQN].e)))
                     + 48'(res_q[SQN] >> 1);
      qt_d[DV0][j] = '0;
    end
    for (int s = DV0 + 1; s <= DVN; s++) begin
      root_d[s] = root_q[s - 1];
      dv = 48'(root_q[s - 1]) << (DVN - s);
      for (int j = 0; j < 4; j++) begin
        if (dn_q[s - 1][j] >= dv) begin
          dn_d[s][j] = dn_q[s - 1][j] - dv;
          qt_d[s][j] = qt_q[s - 1][j] | (16'd1 << (DVN - s));
        end else begin
          dn_d[s][j] = dn_q[s - 1][j];
          qt_d[s][j] = qt_q[s - 1][j];
        end
      end
    end
    for (int j = 0; j < 4; j++) begin
      if (qt_q[DVN][j] > 16'(ONE)) begin
        u_d[j] = c_q[DVN].neg[j] ? -ONE : ONE;
      end else begin
        u_d[j] = c_q[DVN].neg[j] ? -$signed(qt_q[DVN][j]) : $signed(qt_q[DVN][j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q[0] <= c0_d;
      c_q[1] <= c_q[0];
      c_q[2] <= c2_d;
      for (int s = 3; s <= LST; s++) begin
        c_q[s] <= c_q[s - 1];
      end
      sq_q <= sq_d;
      x_q <= x_d;
      rem_q <= rem_d;
      res_q <= res_d;
      dn_q <= dn_d;
      qt_q <= qt_d;
      root_q <= root_d;
      u_q <= u_d;
    end
  end

  assign u_o = u_q;
  assign nz_o = c_q[LST].nz;

endmodule

// ===== hdl/arpt_q2m.sv =====
// Two-stage quaternion to rotation matrix conversion, row-major output.
// Uses arpt_pkg for rounding and clamping.
module arpt_q2m (
  input  logic          clk_i,
  input  logic          en_i,
  input  arpt_pkg::q_t  q_i [4],
  output arpt_pkg::q_t  m_o [9]
);
  import arpt_pkg::*;

  logic signed [31:0] p_q [9];
  logic signed [31:0] p_d [9];
  q_t                 m_q [9];
  q_t                 m_d [9];

  always_comb begin
    logic signed [63:0] yy, zz, xy, zw, xz, yw, xx, yz, xw;
    p_d[0] = q_i[0] * q_i[0];
    p_d[1] = q_i[1] * q_i[1];
    p_d[2] = q_i[2] * q_i[2];
    p_d[3] = q_i[0] * q_i[1];
    p_d[4] = q_i[2] * q_i[3];
    p_d[5] = q_i[0] * q_i[2];
    p_d[6] = q_i[1] * q_i[3];
    p_d[7] = q_i[1] * q_i[2];
    p_d[8] = q_i[0] * q_i[3];
    xx = 64'(p_q[0]); yy = 64'(p_q[1]); zz = 64'(p_q[2]);
    xy = 64'(p_q[3]); zw = 64'(p_q[4]); xz = 64'(p_q[5]);
    yw = 64'(p_q[6]); yz = 64'(p_q[7]); xw = 64'(p_q[8]);
    m_d[0] = clamp_one(rnd_q(ONE2 - 2 * (yy + zz)));
    m_d[1] = clamp_one(rnd_q(2 * (xy - zw)));
    m_d[2] = clamp_one(rnd_q(2 * (xz + yw)));
    m_d[3] = clamp_one(rnd_q(2 * (xy + zw)));
    m_d[4] = clamp_one(rnd_q(ONE2 - 2 * (xx + zz)));
    m_d[5] = clamp_one(rnd_q(2 * (yz - xw)));
    m_d[6] = clamp_one(rnd_q(2 * (xz - yw)));
    m_d[7] = clamp_one(rnd_q(2 * (yz + xw)));
    m_d[8] = clamp_one(rnd_q(ONE2 - 2 * (xx + yy)));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
      m_q <= m_d;
    end
  end

  assign m_o = m_q;

endmodule
